>>> rtl/icv_pkg.sv
// Package with shared constants and types of the integer 2-D convolution unit.
package icv_pkg;

	localparam int MAX_KERNEL      = 5;
	localparam int DEF_MAX_WIDTH   = 1024;
	localparam int DEF_MAX_HEIGHT  = 1024;
	localparam int DIM_W           = 13;
	localparam int Q_DEPTH         = 4;
	localparam int QLW             = $clog2(Q_DEPTH + 1);
	localparam int COEF_N          = MAX_KERNEL * MAX_KERNEL;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_KSIZE  = 2'd2;

	localparam logic FUNC_COEF  = 1'b0;
	localparam logic FUNC_PIXEL = 1'b1;

	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic [2:0]       ksize;
	} icv_cfg_t;

	typedef logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][7:0] icv_win_t;

	typedef struct packed {
		logic               is_coef;
		logic [4:0]         coef_index;
		logic signed [15:0] coef_value;
		icv_win_t           win;
		logic               frame_end;
	} icv_entry_t;

endpackage

>>> rtl/icv_if.sv
// Stream interfaces for the input items and the result items.
interface icv_in_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic [4:0]         coef_index;
	logic signed [15:0] coef_value;
	logic [7:0]         pixel;

	modport source (output valid, func, coef_index, coef_value, pixel, input ready);
	modport sink (input valid, func, coef_index, coef_value, pixel, output ready);
endinterface

interface icv_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] sum;
	logic               frame_end;

	modport source (output valid, sum, frame_end, input ready);
	modport sink (input valid, sum, frame_end, output ready);
endinterface

>>> rtl/icv_queue.sv
// Short queue of classified work entries between the front and back parts.
module icv_queue
	import icv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  icv_entry_t wdata,
	input  logic       pop,
	output icv_entry_t head,
	output logic       empty,
	output logic       full,
	output logic [QLW-1:0] level
);
	localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

	icv_entry_t       slot_q [Q_DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [QLW-1:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == QLW'(Q_DEPTH));
	assign level = cnt_q;
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

>>> rtl/icv_front.sv
// Front part: accepts items, tracks the pixel position, keeps line buffers and the window.
module icv_front
	import icv_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic           clk,
	input  logic           arst_n,
	icv_in_if.sink         in_ch,
	input  icv_cfg_t       cfg,
	input  logic           restart,
	input  logic [QLW-1:0] level,
	output logic           push,
	output icv_entry_t     entry
);
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int NS  = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
	localparam int LBW = NS * 8;

	logic [LBW-1:0] mem [MAX_WIDTH];
	logic [LBW-1:0] rdata_q;
	logic [LBW-1:0] wr_q;
	logic           fwd_q;
	logic [CW-1:0]  col_q;
	logic [RW-1:0]  row_q;
	icv_win_t       win_q;

	logic               v_s1;
	logic               coef_s1;
	logic [4:0]         idx_s1;
	logic signed [15:0] val_s1;
	logic [7:0]         pix_s1;
	logic [CW-1:0]      col_s1;
	logic               ok_s1;
	logic               fe_s1;

	logic                 accept;
	logic [DIM_W-1:0]     col_nx;
	logic [DIM_W-1:0]     row_nx;
	logic                 win_ok;
	logic                 last_col;
	logic                 last_row;
	logic [LBW-1:0]       rdata_eff;
	logic [LBW-1:0]       newvec;
	logic [MAX_KERNEL-1:0][7:0] newcol;
	icv_win_t             win_nx;
	logic                 pix_wr;

	assign in_ch.ready = (int'(level) + int'(v_s1)) < Q_DEPTH;
	assign accept      = in_ch.valid && in_ch.ready;
	assign pix_wr      = v_s1 && !coef_s1;

	assign col_nx   = DIM_W'(col_q) + 1'b1;
	assign row_nx   = DIM_W'(row_q) + 1'b1;
	assign last_col = (col_nx >= cfg.width);
	assign last_row = (row_nx >= cfg.height);
	assign win_ok   = (row_nx >= DIM_W'(cfg.ksize)) && (col_nx >= DIM_W'(cfg.ksize));

	assign rdata_eff = fwd_q ? wr_q : rdata_q;

	always_comb begin
		int age;
		for (int i = 0; i < NS; i++) begin
			newvec[i*8 +: 8] = (i == 0) ? pix_s1 : rdata_eff[(i-1)*8 +: 8];
		end
		for (int m = 0; m < MAX_KERNEL; m++) begin
			age = int'(cfg.ksize) - 1 - m;
			newcol[m] = pix_s1;
			for (int s = 0; s < MAX_KERNEL - 1; s++) begin
				if (age == s + 1) begin
					newcol[m] = rdata_eff[s*8 +: 8];
				end
			end
		end
		for (int n = 0; n < MAX_KERNEL; n++) begin
			win_nx[n] = win_q[n];
			if (n == int'(cfg.ksize) - 1) begin
				win_nx[n] = newcol;
			end else if (n < int'(cfg.ksize) - 1 && n < MAX_KERNEL - 1) begin
				win_nx[n] = win_q[n+1];
			end
		end
	end

	assign push             = v_s1 && (coef_s1 || ok_s1);
	assign entry.is_coef    = coef_s1;
	assign entry.coef_index = idx_s1;
	assign entry.coef_value = val_s1;
	assign entry.win        = win_nx;
	assign entry.frame_end  = fe_s1;

	always_ff @(posedge clk) begin
		if (pix_wr) begin
			mem[col_s1] <= newvec;
		end
		rdata_q <= mem[col_q];
		wr_q    <= newvec;
		fwd_q   <= pix_wr && (col_s1 == col_q);
		if (pix_wr) begin
			win_q <= win_nx;
		end
		if (accept) begin
			coef_s1 <= (in_ch.func == FUNC_COEF);
			idx_s1  <= in_ch.coef_index;
			val_s1  <= in_ch.coef_value;
			pix_s1  <= in_ch.pixel;
			col_s1  <= col_q;
			ok_s1   <= win_ok;
			fe_s1   <= last_col && last_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			col_q <= '0;
			row_q <= '0;
		end else begin
			v_s1 <= accept;
			if (restart) begin
				col_q <= '0;
				row_q <= '0;
			end else if (accept && in_ch.func == FUNC_PIXEL) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : RW'(row_nx);
				end else begin
					col_q <= CW'(col_nx);
				end
			end
		end
	end
endmodule

>>> rtl/icv_back.sv
// Back part: holds the coefficients and computes the window sum of products.
module icv_back
	import icv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  icv_entry_t head,
	input  logic       empty,
	input  logic [2:0] ksize,
	output logic       pop,
	icv_out_if.source  out_ch
);
	logic signed [15:0] coef_q [COEF_N];
	logic signed [23:0] prod_s1 [MAX_KERNEL][MAX_KERNEL];
	logic signed [31:0] row_s2 [MAX_KERNEL];
	logic               v_s1, v_s2, out_v_q;
	logic               fe_s1, fe_s2, fe_q;
	logic signed [31:0] sum_q;
	logic               en;
	logic signed [31:0] rsum [MAX_KERNEL];
	logic signed [31:0] tot;

	assign en  = !out_v_q || out_ch.ready;
	assign pop = en && !empty;

	assign out_ch.valid     = out_v_q;
	assign out_ch.sum       = sum_q;
	assign out_ch.frame_end = fe_q;

	always_comb begin
		tot = '0;
		for (int m = 0; m < MAX_KERNEL; m++) begin
			rsum[m] = '0;
			for (int n = 0; n < MAX_KERNEL; n++) begin
				rsum[m] = rsum[m] + 32'(prod_s1[m][n]);
			end
			tot = tot + row_s2[m];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int m = 0; m < MAX_KERNEL; m++) begin
				for (int n = 0; n < MAX_KERNEL; n++) begin
					if (m < int'(ksize) && n < int'(ksize)) begin
						prod_s1[m][n] <= 24'($signed({1'b0, head.win[n][m]}) *
							coef_q[m*MAX_KERNEL + n]);
					end else begin
						prod_s1[m][n] <= '0;
					end
				end
				row_s2[m] <= rsum[m];
			end
			fe_s1 <= head.frame_end;
			fe_s2 <= fe_s1;
			fe_q  <= fe_s2;
			sum_q <= tot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
			for (int i = 0; i < COEF_N; i++) begin
				coef_q[i] <= '0;
			end
		end else if (en) begin
			v_s1    <= pop && !head.is_coef;
			v_s2    <= v_s1;
			out_v_q <= v_s2;
			if (pop && head.is_coef && int'(head.coef_index) < COEF_N) begin
				coef_q[head.coef_index] <= head.coef_value;
			end
		end
	end
endmodule

>>> rtl/integer_2d_convolution_valid_unit.sv
// Top level: register port, front part, work queue and back part.
// A window's sum passes the front stage, work queue, product, row-sum and output registers.
// Throughput: one item per cycle unless stalled; set by four-entry queue, one front stage.
// Coefficient items and pixels that complete no window give no result.
// Reset is asynchronous and active low; it clears counters, coefficients and registers
// to width 1024, height 1024, kernel size 3; line buffers need no clearing.
module integer_2d_convolution_valid_unit
	import icv_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	icv_in_if.sink      in_ch,
	icv_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [10:0] width_q;
	logic [10:0] height_q;
	logic [2:0]  ksize_q;
	logic        wr;
	logic        restart;
	icv_cfg_t    cfg;
	logic           push, pop, empty, full;
	logic [QLW-1:0] level;
	icv_entry_t     entry, head;

	assign pready  = 1'b1;
	assign wr      = psel && penable && pwrite;
	assign restart = wr && (paddr[3:2] == REG_WIDTH || paddr[3:2] == REG_HEIGHT ||
		paddr[3:2] == REG_KSIZE);

	always_comb begin
		unique case (paddr[3:2])
			REG_WIDTH:  prdata = {21'd0, width_q};
			REG_HEIGHT: prdata = {21'd0, height_q};
			REG_KSIZE:  prdata = {29'd0, ksize_q};
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd1024;
			height_q <= 11'd1024;
			ksize_q  <= 3'd3;
		end else if (wr) begin
			unique case (paddr[3:2])
				REG_WIDTH:  width_q  <= pwdata[10:0];
				REG_HEIGHT: height_q <= pwdata[10:0];
				REG_KSIZE:  ksize_q  <= pwdata[2:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		cfg.width = DIM_W'(width_q);
		if (width_q == '0) begin
			cfg.width = DIM_W'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			cfg.width = DIM_W'(MAX_WIDTH);
		end
		cfg.height = DIM_W'(height_q);
		if (height_q == '0) begin
			cfg.height = DIM_W'(1);
		end else if (int'(height_q) > MAX_HEIGHT) begin
			cfg.height = DIM_W'(MAX_HEIGHT);
		end
		cfg.ksize = ksize_q;
		if (ksize_q == '0) begin
			cfg.ksize = 3'd1;
		end else if (int'(ksize_q) > MAX_KERNEL) begin
			cfg.ksize = 3'(MAX_KERNEL);
		end
	end

	icv_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.cfg     (cfg),
		.restart (restart),
		.level   (level),
		.push    (push),
		.entry   (entry)
	);

	icv_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (entry),
		.pop    (pop),
		.head   (head),
		.empty  (empty),
		.full   (full),
		.level  (level)
	);

	icv_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.ksize  (cfg.ksize),
		.pop    (pop),
		.out_ch (out_ch)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop)) else $error("work queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("work queue underflow");

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> (int'(level) < Q_DEPTH)) else $error("ready with full queue");
endmodule

>>> bench/tb_integer_2d_convolution_valid_unit.sv
// Testbench of the integer 2-D valid-region convolution unit, checked against its own predictor.
module tb_integer_2d_convolution_valid_unit;
	import icv_pkg::*;

	typedef struct {
		logic               func;
		logic [4:0]         idx;
		logic signed [15:0] val;
		logic [7:0]         pix;
		bit                 typed;
		int                 sum;
		bit                 fe;
	} stim_row_t;

	typedef struct {
		logic signed [31:0] sum;
		logic               frame_end;
	} conv_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	icv_in_if  in_ch();
	icv_out_if out_ch();

	integer_2d_convolution_valid_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	logic [10:0] cfg_width = 11'd1024;
	logic [10:0] cfg_height = 11'd1024;
	logic [2:0]  cfg_ksize = 3'd3;
	logic [7:0]  line_pixels [MAX_KERNEL][1024];
	int          kernel_coefs [COEF_N];
	int          col_pos = 0;
	int          row_pos = 0;

	conv_result_t pending_sums [$];
	int           fail_count = 0;
	int           items_sent = 0;
	int           quiet_cycles = 0;
	bit           no_idle = 1'b0;
	int           ready_hold = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int clamp_dim(int v, int lo, int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic void predict_window(input logic func, input logic [4:0] idx,
			input logic signed [15:0] val, input logic [7:0] pix,
			output bit has, output conv_result_t res);
		int w, h, k, c, r, sr, sc;
		int acc;
		w = clamp_dim(cfg_width, 1, 1024);
		h = clamp_dim(cfg_height, 1, 1024);
		k = clamp_dim(cfg_ksize, 1, MAX_KERNEL);
		has = 1'b0;
		res.sum = '0;
		res.frame_end = 1'b0;
		if (func == FUNC_COEF) begin
			if (idx < COEF_N) kernel_coefs[idx] = val;
			return;
		end
		c = (col_pos >= w) ? 0 : col_pos;
		r = (row_pos >= h) ? 0 : row_pos;
		line_pixels[r % MAX_KERNEL][c] = pix;
		if (r + 1 >= k && c + 1 >= k) begin
			acc = 0;
			for (int m = 0; m < k; m++) begin
				sr = (r + 1 - k + m) % MAX_KERNEL;
				for (int n = 0; n < k; n++) begin
					sc = c + 1 - k + n;
					acc += int'(line_pixels[sr][sc]) * kernel_coefs[m * MAX_KERNEL + n];
				end
			end
			res.sum = acc;
			res.frame_end = (r == h - 1 && c == w - 1);
			has = 1'b1;
		end
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h) r = 0;
		end
		col_pos = c;
		row_pos = r;
	endfunction

	task automatic send_item(input logic func, input logic [4:0] idx,
			input logic signed [15:0] val, input logic [7:0] pix,
			input bit typed, input int tsum, input bit tfe);
		int gap;
		bit has;
		conv_result_t res;
		gap = gap_len();
		if (gap > 0) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.func <= func;
		in_ch.coef_index <= idx;
		in_ch.coef_value <= val;
		in_ch.pixel <= pix;
		do @(posedge clk); while (!in_ch.ready);
		predict_window(func, idx, val, pix, has, res);
		if (typed && has) begin
			res.sum = tsum;
			res.frame_end = tfe;
		end
		if (has) pending_sums.push_back(res);
		items_sent++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pending_sums.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic reg_write(input logic [1:0] reg_id, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_id, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (reg_id)
			REG_WIDTH: cfg_width = data[10:0];
			REG_HEIGHT: cfg_height = data[10:0];
			default: cfg_ksize = data[2:0];
		endcase
		col_pos = 0;
		row_pos = 0;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_pixel_run(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 29) == 0)
				send_item(FUNC_COEF, 5'($urandom_range(0, 31)), 16'($urandom), 8'd0, 0, 0, 0);
			send_item(FUNC_PIXEL, 5'($urandom), 16'($urandom), 8'($urandom), 0, 0, 0);
		end
	endtask

	task automatic load_kernel();
		logic signed [15:0] v;
		for (int i = 0; i < COEF_N; i++) begin
			case ($urandom_range(0, 9))
				0: v = 16'sh8000;
				1: v = 16'sh7fff;
				2: v = '0;
				default: v = 16'($urandom);
			endcase
			send_item(FUNC_COEF, 5'(i), v, 8'($urandom), 0, 0, 0);
		end
		send_item(FUNC_COEF, 5'($urandom_range(COEF_N, 31)), 16'($urandom), 8'd0, 0, 0, 0);
	endtask

	stim_row_t directed_rows [] = '{
		'{FUNC_COEF,  5'd0,  -16'sd32768, 8'd0,   0, 0, 0},
		'{FUNC_COEF,  5'd31, 16'sd32767,  8'd0,   0, 0, 0},
		'{FUNC_COEF,  5'd24, 16'sd32767,  8'd0,   0, 0, 0},
		'{FUNC_PIXEL, 5'd31, 16'sd0,      8'd255, 1, -8355840, 0},
		'{FUNC_PIXEL, 5'd0,  -16'sd1,     8'd0,   1, 0, 0},
		'{FUNC_PIXEL, 5'd0,  16'sd0,      8'd1,   1, -32768, 0},
		'{FUNC_COEF,  5'd0,  16'sd32767,  8'd255, 0, 0, 0},
		'{FUNC_PIXEL, 5'd0,  16'sd0,      8'd255, 1, 8355585, 0},
		'{FUNC_PIXEL, 5'd0,  16'sd0,      8'd128, 1, 4194176, 0},
		'{FUNC_PIXEL, 5'd0,  16'sd0,      8'd1,   1, 32767, 1},
		'{FUNC_COEF,  5'd1,  -16'sd2,     8'd0,   0, 0, 0},
		'{FUNC_COEF,  5'd5,  16'sd3,      8'd0,   0, 0, 0},
		'{FUNC_COEF,  5'd6,  -16'sd32768, 8'd0,   0, 0, 0},
		'{FUNC_PIXEL, 5'd0,  16'sd0,      8'd7,   0, 0, 0},
		'{FUNC_PIXEL, 5'd0,  16'sd0,      8'd200, 0, 0, 0},
		'{FUNC_PIXEL, 5'd0,  16'sd0,      8'd255, 0, 0, 0},
		'{FUNC_PIXEL, 5'd0,  16'sd0,      8'd9,   0, 0, 0},
		'{FUNC_PIXEL, 5'd0,  16'sd0,      8'd0,   0, 0, 0},
		'{FUNC_PIXEL, 5'd0,  16'sd0,      8'd255, 0, 0, 0}
	};

	initial begin
		int w, h, k;
		in_ch.valid = 1'b0;
		in_ch.func = FUNC_PIXEL;
		in_ch.coef_index = '0;
		in_ch.coef_value = '0;
		in_ch.pixel = '0;
		for (int i = 0; i < COEF_N; i++) kernel_coefs[i] = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		reg_write(REG_WIDTH, 32'd3);
		reg_write(REG_HEIGHT, 32'd2);
		reg_write(REG_KSIZE, 32'd1);
		foreach (directed_rows[i]) begin
			if (i == 10) begin
				drain_results();
				reg_write(REG_KSIZE, 32'd2);
			end
			send_item(directed_rows[i].func, directed_rows[i].idx, directed_rows[i].val,
				directed_rows[i].pix, directed_rows[i].typed, directed_rows[i].sum,
				directed_rows[i].fe);
		end

		drain_results();
		reg_write(REG_WIDTH, 32'd0);
		reg_write(REG_HEIGHT, 32'h7ff);
		reg_write(REG_KSIZE, 32'd0);
		send_pixel_run(40);
		drain_results();
		reg_write(REG_WIDTH, 32'hffff_ffff);
		reg_write(REG_HEIGHT, 32'd1);
		reg_write(REG_KSIZE, 32'd7);
		send_pixel_run(30);
		drain_results();
		reg_write(REG_WIDTH, 32'd1024);
		reg_write(REG_HEIGHT, 32'd2);
		reg_write(REG_KSIZE, 32'd2);
		load_kernel();
		send_pixel_run(1030);

		while (items_sent < 1700) begin
			drain_results();
			no_idle = ($urandom_range(0, 4) == 0);
			w = $urandom_range(1, 12);
			h = $urandom_range(1, 8);
			k = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 5);
			reg_write(REG_WIDTH, 32'(w));
			reg_write(REG_HEIGHT, 32'(h));
			reg_write(REG_KSIZE, 32'(k));
			load_kernel();
			if ($urandom_range(0, 3) == 0) begin
				send_pixel_run($urandom_range(1, w * h));
				drain_results();
			end
			send_pixel_run(w * h * $urandom_range(1, 3) + $urandom_range(0, w));
		end
		no_idle = 1'b0;
		drain_results();
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	always @(negedge clk) begin
		if (ready_hold > 0) begin
			out_ch.ready <= 1'b0;
			ready_hold <= ready_hold - 1;
		end else begin
			out_ch.ready <= 1'b1;
			if ($urandom_range(0, 7) == 0) ready_hold <= gap_len();
		end
	end

	always @(posedge clk) begin
		conv_result_t exp_res;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_sums.size() == 0) begin
				$error("sum: unexpected transfer, actual %0d", out_ch.sum);
				fail_count++;
			end else begin
				exp_res = pending_sums.pop_front();
				if (out_ch.sum !== exp_res.sum) begin
					$error("sum: expected %0d, actual %0d", exp_res.sum, out_ch.sum);
					fail_count++;
				end
				if (out_ch.frame_end !== exp_res.frame_end) begin
					$error("frame_end: expected %0d, actual %0d", exp_res.frame_end,
						out_ch.frame_end);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 5000) begin
			$display("== FAIL ==");
			$finish;
		end
	end

endmodule
